// ===== sv/tafl_pkg.sv =====
// Shared constants and types for the temperature average and fire lockout controller.
// Used by tafl_div, tafl_ring, the top level and the checker. No dependencies.
package tafl_pkg;

  // default ring depth
  localparam int WINDOW_SAMPLES_DEF = 8;

  // scaling of the converter code to hundredths of a degree
  localparam int ADC_W            = 12;
  localparam int TEMP_W           = 16;
  localparam int FULL_SCALE_CENTI = 33000;
  localparam int CODE_SPAN        = 4095;

  // widths: DVD_W covers code*33000 and the window sum, DIV_W covers the sample count
  localparam int DVD_W = 28;
  localparam int DIV_W = 12;

  // timestamp and configuration
  localparam int TIME_W    = 32;
  localparam int REG_IDX_W = 2;
  localparam int CFG_W     = 32;

  localparam logic [REG_IDX_W-1:0] REG_HIGH_THR = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOW_THR  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOCK_DUR = 2'd2;

  localparam logic [TEMP_W-1:0] HIGH_THR_RST = 16'd3000;
  localparam logic [TEMP_W-1:0] LOW_THR_RST  = 16'd1500;
  localparam logic [TIME_W-1:0] LOCK_DUR_RST = 32'd10000;

  // stream payload widths
  localparam int IN_W  = 48;
  localparam int OUT_W = 40;

  // request to the divider
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  // response from the divider
  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== sv/tafl_div.sv =====
// Restoring serial divider, one quotient bit per cycle, used for the window
// average. Depends on tafl_pkg.
module tafl_div (
  input  logic              clk,
  input  logic              rst,
  input  tafl_pkg::div_req_t req,
  output tafl_pkg::div_rsp_t rsp
);

  localparam int DvdW = tafl_pkg::DVD_W;
  localparam int DivW = tafl_pkg::DIV_W;
  localparam int CntW = $clog2(DvdW + 1);

  logic            busy;
  logic            done;
  logic [CntW-1:0] cnt;
  logic [DivW-1:0] rem;
  logic [DivW-1:0] dsr;
  logic [DvdW-1:0] dvd;

  logic [DivW:0]   trial;
  logic            fits;

  // trial subtraction for the current bit
  assign trial = {rem, dvd[DvdW-1]};
  assign fits  = (trial >= {1'b0, dsr});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CntW'(DvdW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: the dividend register fills with quotient bits from the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dsr <= req.divisor;
      dvd <= req.dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= DivW'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[DivW-1:0];
      end
      dvd <= {dvd[DvdW-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

// ===== sv/tafl_ring.sv =====
// Sample ring memory: one write port, one read port with registered read data.
// Depends on tafl_pkg.
module tafl_ring #(
  parameter  int DEPTH = tafl_pkg::WINDOW_SAMPLES_DEF,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AddrW-1:0]              wr_addr,
  input  logic [tafl_pkg::TEMP_W-1:0]   wr_data,
  input  logic [AddrW-1:0]              rd_addr,
  output logic [tafl_pkg::TEMP_W-1:0]   rd_data
);

  logic [tafl_pkg::TEMP_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/temp_average_fire_lockout_ctrl.sv =====
// Flow from input to result transaction: a fold and a scale state for the scaling, a summing
// pass of one ring entry a cycle and 28 steps of the serial divider for the average. The
// input is ready only while idle, so a new item is taken only after the last result is
// loaded into the output register; a stalled result holds the input not ready.
// Reset (rst, synchronous, active high) empties the window, clears the lockout and
// sounder, loads register defaults; ring contents stay undefined until written.
module temp_average_fire_lockout_ctrl #(
  parameter int WINDOW_SAMPLES = tafl_pkg::WINDOW_SAMPLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // adc_code[11:0], fire_a[12], fire_b[13], now_ms[45:14], zero fill [47:46]
  input  logic [tafl_pkg::IN_W-1:0]         s_tdata,
  // adc_valid[0]
  input  logic                              s_tuser,
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // current_temp_centi[15:0], average_temp_centi[31:16], fan_on[32], heater_on[33],
  // sprinkler_a[34], sprinkler_b[35], buzzer_level[36], fire_locked[37], zero fill [39:38]
  output logic [tafl_pkg::OUT_W-1:0]        m_tdata,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tafl_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [tafl_pkg::CFG_W-1:0]        cfg_data
);

  localparam int DvdW  = tafl_pkg::DVD_W;
  localparam int DivW  = tafl_pkg::DIV_W;
  localparam int TempW = tafl_pkg::TEMP_W;
  localparam int TimeW = tafl_pkg::TIME_W;
  localparam int AdcW  = tafl_pkg::ADC_W;
  localparam int FoldW = TempW + 1;
  localparam int AddrW = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
  localparam int CntW  = $clog2(WINDOW_SAMPLES + 1);
  localparam int SumW  = TempW + CntW;

  // sequencer states
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_FOLD     = 3'd1;
  localparam logic [2:0] ST_SCALE    = 3'd2;
  localparam logic [2:0] ST_SUM      = 3'd3;
  localparam logic [2:0] ST_AVG_GO   = 3'd4;
  localparam logic [2:0] ST_AVG_WAIT = 3'd5;
  localparam logic [2:0] ST_FIN      = 3'd6;

  logic [2:0]       state;

  // configuration registers
  logic [TempW-1:0] high_thr;
  logic [TempW-1:0] low_thr;
  logic [TimeW-1:0] lock_dur;

  // window bookkeeping
  logic [AddrW-1:0] write_slot;
  logic [CntW-1:0]  held;
  logic [CntW-1:0]  sum_idx;
  logic [SumW-1:0]  sum;

  // lockout state
  logic             locked;
  logic [TimeW-1:0] last_fire;
  logic             sounder;

  // per-item registers
  logic [DvdW-1:0]  prod;
  logic [TempW-1:0] scale_q;
  logic [FoldW-1:0] scale_r;
  logic [TempW-1:0] cur;
  logic [TempW-1:0] avg;
  logic             spa;
  logic             spb;

  // scaling result
  logic [AdcW:0]    scale_z;
  logic [TempW-1:0] scale_res;

  // input field views
  logic [AdcW-1:0]  in_code;
  logic             in_fa;
  logic             in_fb;
  logic [TimeW-1:0] in_now;
  logic             in_acc;

  logic             locked_next;
  logic             sounder_next;
  logic [TimeW-1:0] elapsed;

  tafl_pkg::div_req_t div_req;
  tafl_pkg::div_rsp_t div_rsp;

  logic             ring_we;
  logic [AddrW-1:0] ring_rd_addr;
  logic [TempW-1:0] ring_rd_data;

  logic             out_load;
  logic             fan;
  logic             heat;

  assign in_code = s_tdata[11:0];
  assign in_fa   = s_tdata[12];
  assign in_fb   = s_tdata[13];
  assign in_now  = s_tdata[45:14];

  assign s_tready  = (state == ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // configuration write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      high_thr <= tafl_pkg::HIGH_THR_RST;
      low_thr  <= tafl_pkg::LOW_THR_RST;
      lock_dur <= tafl_pkg::LOCK_DUR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tafl_pkg::REG_HIGH_THR: high_thr <= cfg_data[TempW-1:0];
        tafl_pkg::REG_LOW_THR:  low_thr  <= cfg_data[TempW-1:0];
        tafl_pkg::REG_LOCK_DUR: lock_dur <= cfg_data[TimeW-1:0];
        default: ;
      endcase
    end
  end

  // lockout decision for the item being accepted
  assign elapsed = in_now - last_fire;

  always_comb begin
    locked_next = locked;
    if (in_fa || in_fb) begin
      locked_next = 1'b1;
    end else if (locked && (elapsed >= lock_dur)) begin
      locked_next = 1'b0;
    end
    sounder_next = locked_next ? ~sounder : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      locked    <= 1'b0;
      sounder   <= 1'b0;
      last_fire <= '0;
    end else if (in_acc) begin
      locked  <= locked_next;
      sounder <= sounder_next;
      if (in_fa || in_fb) begin
        last_fire <= in_now;
      end
    end
  end

  // item capture: scaled product and sprinkler drive
  always_ff @(posedge clk) begin
    if (in_acc) begin
      prod <= s_tuser ? DvdW'(in_code) * DvdW'(tafl_pkg::FULL_SCALE_CENTI) : '0;
      spa  <= locked_next && in_fa;
      spb  <= locked_next && in_fb;
    end
  end

  // division by the code span 2^12-1: fold the high part onto the low part twice,
  // then one compare settles the last step
  always_ff @(posedge clk) begin
    if (state == ST_FOLD) begin
      scale_q <= prod[DvdW-1:AdcW];
      scale_r <= FoldW'(prod[DvdW-1:AdcW]) + FoldW'(prod[AdcW-1:0]);
    end
  end

  assign scale_z   = (AdcW+1)'(scale_r[FoldW-1:AdcW]) + (AdcW+1)'(scale_r[AdcW-1:0]);
  assign scale_res = scale_q + TempW'(scale_r[FoldW-1:AdcW])
                   + TempW'(scale_z >= (AdcW+1)'(tafl_pkg::CODE_SPAN));

  // divider requests for the average
  always_comb begin
    div_req.start    = (state == ST_AVG_GO);
    div_req.dividend = DvdW'(sum);
    div_req.divisor  = DivW'(held);
  end

  tafl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign ring_we      = (state == ST_SCALE);
  assign ring_rd_addr = sum_idx[AddrW-1:0];

  tafl_ring #(
    .DEPTH (WINDOW_SAMPLES)
  ) u_ring (
    .clk     (clk),
    .we      (ring_we),
    .wr_addr (write_slot),
    .wr_data (scale_res),
    .rd_addr (ring_rd_addr),
    .rd_data (ring_rd_data)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      write_slot <= '0;
      held       <= '0;
      sum_idx    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          write_slot <= (write_slot == AddrW'(WINDOW_SAMPLES - 1)) ? '0 : write_slot + 1'b1;
          if (held != CntW'(WINDOW_SAMPLES)) begin
            held <= held + 1'b1;
          end
          sum_idx <= '0;
          state   <= ST_SUM;
        end
        ST_SUM: begin
          if (sum_idx == held) begin
            state <= ST_AVG_GO;
          end else begin
            sum_idx <= sum_idx + 1'b1;
          end
        end
        ST_AVG_GO: begin
          state <= ST_AVG_WAIT;
        end
        ST_AVG_WAIT: begin
          if (div_rsp.done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers along the sequence
  always_ff @(posedge clk) begin
    if (ring_we) begin
      cur <= scale_res;
      sum <= '0;
    end else if (state == ST_SUM && sum_idx != '0) begin
      sum <= sum + SumW'(ring_rd_data);
    end
    if (state == ST_AVG_WAIT && div_rsp.done) begin
      avg <= div_rsp.quotient[TempW-1:0];
    end
  end

  // thermostat decision, the fan test wins
  assign fan  = (avg > high_thr);
  assign heat = !fan && (avg < low_thr);

  // output register
  assign out_load = (state == ST_FIN) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, locked, sounder, spb, spa, heat, fan, avg, cur};
    end
  end

endmodule

// ===== sv/tafl_checker.sv =====
// Port-level checks for temp_average_fire_lockout_ctrl, with the bind that attaches them.
// Depends on tafl_pkg.
module tafl_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [tafl_pkg::OUT_W-1:0] m_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // temperatures stay within full scale
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] <= 16'd33000) && (m_tdata[31:16] <= 16'd33000))
    else $error("temperature beyond full scale");

  // fan and heater never both on
  a_therm: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[32] && m_tdata[33]))
    else $error("fan and heater both on");

  // sprinklers and sounder only while locked
  a_lock: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[37] |-> !m_tdata[34] && !m_tdata[35] && !m_tdata[36])
    else $error("actuator active while unlocked");

endmodule

bind temp_average_fire_lockout_ctrl tafl_checker u_tafl_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
